// ===== hdl/sas_pkg.sv =====
// Shared types, codes and constants of the suffix array substring search block.
// No dependencies; the files that use this package refer to it by scoped names.
package sas_pkg;

	// Default capacities of the text and pattern stores.
	localparam int TEXT_MAX_DEF    = 1023;
	localparam int PATTERN_MAX_DEF = 64;

	// Sort keys: zero is the sentinel, a byte b sorts as key b + 1.
	localparam int NKEYS = 257;
	localparam int KEY_W = 9;

	// Word widths fixed by the channel payload.
	localparam int RANK_W = 11;

	typedef enum logic [1:0] {
		ACT_TEXT  = 2'd0,
		ACT_BUILD = 2'd1,
		ACT_PAT   = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_TEXT_OVF = 2'd1,
		STAT_PAT_OVF  = 2'd2,
		STAT_NO_BUILD = 2'd3
	} status_t;

	typedef enum logic {
		KIND_BUILD = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	// Sequencer steps. Letters mark the memory access steps of one element.
	typedef enum logic [5:0] {
		ST_IDLE,
		ST_KCLR,
		ST_KCNT_A, ST_KCNT_B, ST_KCNT_C,
		ST_KSUM_A, ST_KSUM_B,
		ST_KPL_A, ST_KPL_B, ST_KPL_C,
		ST_CI_A, ST_CI_B, ST_CI_C,
		ST_SH_A, ST_SH_B,
		ST_BCLR,
		ST_BCNT_A, ST_BCNT_B, ST_BCNT_C,
		ST_BSUM_A, ST_BSUM_B,
		ST_BPL_A, ST_BPL_B, ST_BPL_C, ST_BPL_D,
		ST_CP_A, ST_CP_B,
		ST_RC_A, ST_RC_B, ST_RC_C, ST_RC_D,
		ST_CC_A, ST_CC_B,
		ST_BDONE,
		ST_QM, ST_QP, ST_QC1, ST_QC2,
		ST_QDONE
	} state_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		state_t op;
		logic   accept;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
		logic built;
		logic last_i;
		logic last_k;
		logic n_gt1;
		logic dbl_lt_n;
		logic r_lt_l;
		logic j_eq_plen;
		logic pos_ge_n;
		logic cmp_eq;
	} stat_t;

endpackage

// ===== hdl/sas_if.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing; payload widths are those of the channel words.
interface sas_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] symbol;

	modport source (output valid, action, symbol, input ready);
	modport sink (input valid, action, symbol, output ready);
endinterface

interface sas_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic        found;
	logic [10:0] match_rank;
	logic [1:0]  status;

	modport source (output valid, result_kind, found, match_rank, status, input ready);
	modport sink (input valid, result_kind, found, match_rank, status, output ready);
endinterface

// ===== hdl/sas_ctrl.sv =====
// Sequencer of the suffix array block: walks the sort passes and the search.
// Depends on sas_pkg for the step enum and the command and status structs.
module sas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     action,
	output logic           in_ready,
	input  sas_pkg::stat_t stat,
	output sas_pkg::cmd_t  cmd
);

	sas_pkg::state_t state_q, state_d;
	logic            accept;

	// A load word is taken even while a result waits; build and query need the slot.
	assign in_ready = (state_q == sas_pkg::ST_IDLE) &&
		(!stat.out_busy || action == sas_pkg::ACT_TEXT || action == sas_pkg::ACT_PAT);
	assign accept     = in_valid && in_ready;
	assign cmd.op     = state_q;
	assign cmd.accept = accept;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sas_pkg::ST_IDLE: begin
				if (accept && action == sas_pkg::ACT_BUILD) begin
					state_d = sas_pkg::ST_KCLR;
				end else if (accept && action == sas_pkg::ACT_QUERY) begin
					state_d = stat.built ? sas_pkg::ST_QM : sas_pkg::ST_QDONE;
				end
			end
			sas_pkg::ST_KCLR: if (stat.last_k) state_d = sas_pkg::ST_KCNT_A;
			sas_pkg::ST_KCNT_A: state_d = sas_pkg::ST_KCNT_B;
			sas_pkg::ST_KCNT_B: state_d = sas_pkg::ST_KCNT_C;
			sas_pkg::ST_KCNT_C: begin
				state_d = stat.last_i ? sas_pkg::ST_KSUM_A : sas_pkg::ST_KCNT_A;
			end
			sas_pkg::ST_KSUM_A: state_d = sas_pkg::ST_KSUM_B;
			sas_pkg::ST_KSUM_B: begin
				state_d = stat.last_k ? sas_pkg::ST_KPL_A : sas_pkg::ST_KSUM_A;
			end
			sas_pkg::ST_KPL_A: state_d = sas_pkg::ST_KPL_B;
			sas_pkg::ST_KPL_B: state_d = sas_pkg::ST_KPL_C;
			sas_pkg::ST_KPL_C: begin
				state_d = stat.last_i ? sas_pkg::ST_CI_A : sas_pkg::ST_KPL_A;
			end
			sas_pkg::ST_CI_A: state_d = sas_pkg::ST_CI_B;
			sas_pkg::ST_CI_B: state_d = sas_pkg::ST_CI_C;
			sas_pkg::ST_CI_C: begin
				if (!stat.last_i) begin
					state_d = sas_pkg::ST_CI_A;
				end else begin
					state_d = stat.n_gt1 ? sas_pkg::ST_SH_A : sas_pkg::ST_BDONE;
				end
			end
			sas_pkg::ST_SH_A: state_d = sas_pkg::ST_SH_B;
			sas_pkg::ST_SH_B: begin
				state_d = stat.last_i ? sas_pkg::ST_BCLR : sas_pkg::ST_SH_A;
			end
			sas_pkg::ST_BCLR: if (stat.last_i) state_d = sas_pkg::ST_BCNT_A;
			sas_pkg::ST_BCNT_A: state_d = sas_pkg::ST_BCNT_B;
			sas_pkg::ST_BCNT_B: state_d = sas_pkg::ST_BCNT_C;
			sas_pkg::ST_BCNT_C: begin
				state_d = stat.last_i ? sas_pkg::ST_BSUM_A : sas_pkg::ST_BCNT_A;
			end
			sas_pkg::ST_BSUM_A: state_d = sas_pkg::ST_BSUM_B;
			sas_pkg::ST_BSUM_B: begin
				state_d = stat.last_i ? sas_pkg::ST_BPL_A : sas_pkg::ST_BSUM_A;
			end
			sas_pkg::ST_BPL_A: state_d = sas_pkg::ST_BPL_B;
			sas_pkg::ST_BPL_B: state_d = sas_pkg::ST_BPL_C;
			sas_pkg::ST_BPL_C: state_d = sas_pkg::ST_BPL_D;
			sas_pkg::ST_BPL_D: begin
				state_d = stat.last_i ? sas_pkg::ST_CP_A : sas_pkg::ST_BPL_A;
			end
			sas_pkg::ST_CP_A: state_d = sas_pkg::ST_CP_B;
			sas_pkg::ST_CP_B: begin
				state_d = stat.last_i ? sas_pkg::ST_RC_A : sas_pkg::ST_CP_A;
			end
			sas_pkg::ST_RC_A: state_d = sas_pkg::ST_RC_B;
			sas_pkg::ST_RC_B: state_d = sas_pkg::ST_RC_C;
			sas_pkg::ST_RC_C: state_d = sas_pkg::ST_RC_D;
			sas_pkg::ST_RC_D: begin
				state_d = stat.last_i ? sas_pkg::ST_CC_A : sas_pkg::ST_RC_A;
			end
			sas_pkg::ST_CC_A: state_d = sas_pkg::ST_CC_B;
			sas_pkg::ST_CC_B: begin
				if (!stat.last_i) begin
					state_d = sas_pkg::ST_CC_A;
				end else begin
					state_d = stat.dbl_lt_n ? sas_pkg::ST_SH_A : sas_pkg::ST_BDONE;
				end
			end
			sas_pkg::ST_BDONE: state_d = sas_pkg::ST_IDLE;
			sas_pkg::ST_QM: state_d = stat.r_lt_l ? sas_pkg::ST_QDONE : sas_pkg::ST_QP;
			sas_pkg::ST_QP: state_d = sas_pkg::ST_QC1;
			sas_pkg::ST_QC1: begin
				priority if (stat.j_eq_plen) begin
					state_d = sas_pkg::ST_QDONE;
				end else if (stat.pos_ge_n) begin
					state_d = sas_pkg::ST_QM;
				end else begin
					state_d = sas_pkg::ST_QC2;
				end
			end
			sas_pkg::ST_QC2: state_d = stat.cmp_eq ? sas_pkg::ST_QC1 : sas_pkg::ST_QM;
			sas_pkg::ST_QDONE: state_d = sas_pkg::ST_IDLE;
			default: state_d = sas_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/sas_dp.sv =====
// Datapath of the suffix array block: text, pattern and sort memories,
// counters, comparators and the result register. Depends on sas_pkg.
module sas_dp #(
	parameter int TEXT_MAX    = sas_pkg::TEXT_MAX_DEF,
	parameter int PATTERN_MAX = sas_pkg::PATTERN_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sas_pkg::cmd_t  cmd,
	input  logic [1:0]     action,
	input  logic [7:0]     symbol,
	output sas_pkg::stat_t stat,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           res_kind,
	output logic           res_found,
	output logic [10:0]    res_rank,
	output logic [1:0]     res_status
);

	localparam int D   = TEXT_MAX + 1;
	localparam int AW  = $clog2(D);
	localparam int NW  = $clog2(TEXT_MAX + 2);
	localparam int PW  = $clog2(PATTERN_MAX + 1);
	localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int QW  = ((NW > PW) ? NW : PW) + 1;
	localparam int KW  = sas_pkg::KEY_W;
	localparam int RW  = sas_pkg::RANK_W;

	// Memories.
	logic [7:0]    txt_mem [D];
	logic [NW-1:0] kc_mem [sas_pkg::NKEYS];
	logic [AW-1:0] sa_mem [D];
	logic [AW-1:0] cls_mem [D];
	logic [AW-1:0] ncls_mem [D];
	logic [NW-1:0] bkt_mem [D];
	logic [7:0]    pat_mem [PATTERN_MAX];

	// Port signals.
	logic [AW-1:0]  txt_ra, txt_wa;
	logic           txt_we;
	logic [KW-1:0]  kc_ra, kc_wa;
	logic [NW-1:0]  kc_wd;
	logic           kc_we;
	logic [AW-1:0]  sa_ra, sa_wa, sa_wd;
	logic           sa_we;
	logic [AW-1:0]  cls_ra, cls_wa, cls_wd;
	logic           cls_we;
	logic [AW-1:0]  ncls_ra, ncls_wa, ncls_wd;
	logic           ncls_we;
	logic [AW-1:0]  bkt_ra, bkt_wa;
	logic [NW-1:0]  bkt_wd;
	logic           bkt_we;
	logic [PAW-1:0] pat_ra;
	logic           pat_we;

	// Registered read data.
	logic [7:0]    txt_rd_q;
	logic          txt_lt_q;
	logic [NW-1:0] kc_rd_q;
	logic [AW-1:0] sa_rd_q, cls_rd_q, ncls_rd_q;
	logic [NW-1:0] bkt_rd_q;
	logic [7:0]    pat_rd_q;

	// Control registers.
	logic [NW-1:0] len_q;
	logic [PW-1:0] plen_q;
	logic          built_q;
	logic [1:0]    ovf_q;
	logic          out_valid_q;

	// Sequencing registers.
	logic [NW-1:0] n_q, i_q, sum_q, shift_q;
	logic [KW-1:0] k_q, key_q, prev_key_q;
	logic [AW-1:0] b_q, c_q, x_q, c1_q, prev_c1_q, prev_c2_q, prev_nc_q;
	logic [AW-1:0] m_q, p_q;
	logic [PW-1:0] j_q;
	logic signed [NW:0] l_q, r_q;
	logic          found_q;

	// Result register.
	logic          kind_q, rfound_q;
	logic [RW-1:0] rank_q;
	logic [1:0]    rstat_q;

	// Derived values.
	logic          accept_text, accept_pat;
	logic [NW-1:0] len_eff;
	logic [KW-1:0] key_now, pkey;
	logic [AW-1:0] iaddr, cls_b, shifted, bsh, nc;
	logic [NW:0]   sh_t, bs_t;
	logic          same, step_i, step_k, last_i, last_k;
	logic [NW+1:0] lr_sum;
	logic [AW-1:0] m_next;
	logic [QW-1:0] pos;
	logic [NW:0]   m_plus, m_minus;
	logic [AW+RW-1:0] rank_ext;

	assign iaddr   = i_q[AW-1:0];
	assign last_i  = (i_q == n_q - NW'(1));
	assign last_k  = (k_q == KW'(sas_pkg::NKEYS - 1));
	assign len_eff = built_q ? '0 : len_q;
	assign accept_text = cmd.accept && action == sas_pkg::ACT_TEXT;
	assign accept_pat  = cmd.accept && action == sas_pkg::ACT_PAT;

	// Sort key of the text position read last cycle; the sentinel is key zero.
	assign key_now = txt_lt_q ? ({1'b0, txt_rd_q} + KW'(1)) : '0;
	assign pkey    = {1'b0, pat_rd_q} + KW'(1);

	// Class of a suffix in the initial order.
	assign cls_b = (i_q == '0) ? '0 : (prev_nc_q + AW'(key_now != prev_key_q));

	// Cyclic shift of a suffix start by the current step, modulo n.
	assign sh_t = (NW+1)'(sa_rd_q) + ((NW'(sa_rd_q) >= shift_q) ? (NW+1)'(0) : (NW+1)'(n_q))
		- (NW+1)'(shift_q);
	assign shifted = sh_t[AW-1:0];

	// Position of the second half, modulo n.
	assign bs_t = (NW+1)'(b_q) + (NW+1)'(shift_q);
	assign bsh  = (bs_t >= (NW+1)'(n_q)) ? AW'(bs_t - (NW+1)'(n_q)) : bs_t[AW-1:0];

	// Renumbering of the doubled classes.
	assign same = (i_q != '0) && (c1_q == prev_c1_q) && (cls_rd_q == prev_c2_q);
	assign nc   = (i_q == '0) ? '0 : (prev_nc_q + AW'(!same));

	// Binary search probe and compare position.
	assign lr_sum  = (NW+2)'(unsigned'(l_q)) + (NW+2)'(unsigned'(r_q));
	assign m_next  = lr_sum[AW:1];
	assign pos     = QW'(p_q) + QW'(j_q);
	assign m_plus  = (NW+1)'(m_q) + (NW+1)'(1);
	assign m_minus = (NW+1)'(m_q) - (NW+1)'(1);
	assign rank_ext = (AW+RW)'(m_q);

	// Memory port selection for each step.
	always_comb begin
		txt_ra = iaddr;
		txt_wa = len_eff[AW-1:0];
		txt_we = accept_text && (len_eff < NW'(TEXT_MAX));
		kc_ra = k_q;  kc_wa = k_q;  kc_wd = '0;  kc_we = 1'b0;
		sa_ra = iaddr;  sa_wa = iaddr;  sa_wd = '0;  sa_we = 1'b0;
		cls_ra = iaddr;  cls_wa = iaddr;  cls_wd = '0;  cls_we = 1'b0;
		ncls_ra = iaddr;  ncls_wa = iaddr;  ncls_wd = '0;  ncls_we = 1'b0;
		bkt_ra = iaddr;  bkt_wa = iaddr;  bkt_wd = '0;  bkt_we = 1'b0;
		pat_ra = j_q[PAW-1:0];
		pat_we = accept_pat && (plen_q < PW'(PATTERN_MAX));
		step_i = 1'b0;
		step_k = 1'b0;
		unique case (cmd.op)
			sas_pkg::ST_KCLR: begin
				kc_we = 1'b1;  step_k = 1'b1;
			end
			sas_pkg::ST_KCNT_B, sas_pkg::ST_KPL_B: kc_ra = key_now;
			sas_pkg::ST_KCNT_C: begin
				kc_we = 1'b1;  kc_wa = key_q;  kc_wd = kc_rd_q + NW'(1);  step_i = 1'b1;
			end
			sas_pkg::ST_KSUM_B: begin
				kc_we = 1'b1;  kc_wd = sum_q;  step_k = 1'b1;
			end
			sas_pkg::ST_KPL_C: begin
				sa_we = 1'b1;  sa_wa = kc_rd_q[AW-1:0];  sa_wd = iaddr;
				kc_we = 1'b1;  kc_wa = key_q;  kc_wd = kc_rd_q + NW'(1);  step_i = 1'b1;
			end
			sas_pkg::ST_CI_B: txt_ra = sa_rd_q;
			sas_pkg::ST_CI_C: begin
				cls_we = 1'b1;  cls_wa = b_q;  cls_wd = cls_b;  step_i = 1'b1;
			end
			sas_pkg::ST_SH_B: begin
				sa_we = 1'b1;  sa_wd = shifted;  step_i = 1'b1;
			end
			sas_pkg::ST_BCLR: begin
				bkt_we = 1'b1;  step_i = 1'b1;
			end
			sas_pkg::ST_BCNT_B, sas_pkg::ST_BPL_C: bkt_ra = cls_rd_q;
			sas_pkg::ST_BCNT_C: begin
				bkt_we = 1'b1;  bkt_wa = c_q;  bkt_wd = bkt_rd_q + NW'(1);  step_i = 1'b1;
			end
			sas_pkg::ST_BSUM_B: begin
				bkt_we = 1'b1;  bkt_wd = sum_q;  step_i = 1'b1;
			end
			sas_pkg::ST_BPL_B, sas_pkg::ST_RC_B: cls_ra = sa_rd_q;
			sas_pkg::ST_BPL_D: begin
				ncls_we = 1'b1;  ncls_wa = bkt_rd_q[AW-1:0];  ncls_wd = x_q;
				bkt_we = 1'b1;  bkt_wa = c_q;  bkt_wd = bkt_rd_q + NW'(1);  step_i = 1'b1;
			end
			sas_pkg::ST_CP_B: begin
				sa_we = 1'b1;  sa_wd = ncls_rd_q;  step_i = 1'b1;
			end
			sas_pkg::ST_RC_C: cls_ra = bsh;
			sas_pkg::ST_RC_D: begin
				ncls_we = 1'b1;  ncls_wa = b_q;  ncls_wd = nc;  step_i = 1'b1;
			end
			sas_pkg::ST_CC_B: begin
				cls_we = 1'b1;  cls_wd = ncls_rd_q;  step_i = 1'b1;
			end
			sas_pkg::ST_QM: sa_ra = m_next;
			sas_pkg::ST_QC1: txt_ra = pos[AW-1:0];
			default: begin
			end
		endcase
	end

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (txt_we) txt_mem[txt_wa] <= symbol;
		if (kc_we) kc_mem[kc_wa] <= kc_wd;
		if (sa_we) sa_mem[sa_wa] <= sa_wd;
		if (cls_we) cls_mem[cls_wa] <= cls_wd;
		if (ncls_we) ncls_mem[ncls_wa] <= ncls_wd;
		if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
		if (pat_we) pat_mem[plen_q[PAW-1:0]] <= symbol;
		txt_rd_q  <= txt_mem[txt_ra];
		txt_lt_q  <= (NW'(txt_ra) < len_q);
		kc_rd_q   <= kc_mem[kc_ra];
		sa_rd_q   <= sa_mem[sa_ra];
		cls_rd_q  <= cls_mem[cls_ra];
		ncls_rd_q <= ncls_mem[ncls_ra];
		bkt_rd_q  <= bkt_mem[bkt_ra];
		pat_rd_q  <= pat_mem[pat_ra];
	end

	// Text, pattern and flag state, and the result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			plen_q      <= '0;
			built_q     <= 1'b0;
			ovf_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept_text) begin
				built_q <= 1'b0;
				if (len_eff < NW'(TEXT_MAX)) begin
					len_q    <= len_eff + NW'(1);
					ovf_q[0] <= built_q ? 1'b0 : ovf_q[0];
				end else begin
					len_q    <= len_eff;
					ovf_q[0] <= 1'b1;
				end
			end
			if (accept_pat) begin
				if (plen_q < PW'(PATTERN_MAX)) begin
					plen_q <= plen_q + PW'(1);
				end else begin
					ovf_q[1] <= 1'b1;
				end
			end
			if (cmd.op == sas_pkg::ST_BDONE) begin
				built_q  <= 1'b1;
				ovf_q[0] <= 1'b0;
			end
			if (cmd.op == sas_pkg::ST_QDONE) begin
				plen_q   <= '0;
				ovf_q[1] <= 1'b0;
			end
			if (cmd.op == sas_pkg::ST_BDONE || cmd.op == sas_pkg::ST_QDONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Counters and element registers of the sort and search.
	always_ff @(posedge clk) begin
		if (cmd.accept && action == sas_pkg::ACT_BUILD) begin
			n_q   <= len_q + NW'(1);
			i_q   <= '0;
			k_q   <= '0;
			sum_q <= '0;
		end
		if (cmd.accept && action == sas_pkg::ACT_QUERY) begin
			found_q <= 1'b0;
			l_q     <= '0;
			r_q     <= signed'((NW+1)'(len_q));
		end
		if (step_i) i_q <= last_i ? '0 : (i_q + NW'(1));
		if (step_k) k_q <= last_k ? '0 : (k_q + KW'(1));

		unique case (cmd.op)
			sas_pkg::ST_KCNT_B, sas_pkg::ST_KPL_B: key_q <= key_now;
			sas_pkg::ST_KSUM_B: sum_q <= sum_q + kc_rd_q;
			sas_pkg::ST_CI_B, sas_pkg::ST_RC_B: b_q <= sa_rd_q;
			sas_pkg::ST_CI_C: begin
				prev_key_q <= key_now;
				prev_nc_q  <= cls_b;
				if (last_i) shift_q <= NW'(1);
			end
			sas_pkg::ST_BCLR: sum_q <= '0;
			sas_pkg::ST_BCNT_B, sas_pkg::ST_BPL_C: c_q <= cls_rd_q;
			sas_pkg::ST_BSUM_B: sum_q <= sum_q + bkt_rd_q;
			sas_pkg::ST_BPL_B: x_q <= sa_rd_q;
			sas_pkg::ST_RC_C: c1_q <= cls_rd_q;
			sas_pkg::ST_RC_D: begin
				prev_c1_q <= c1_q;
				prev_c2_q <= cls_rd_q;
				prev_nc_q <= nc;
			end
			sas_pkg::ST_CC_B: if (last_i) shift_q <= {shift_q[NW-2:0], 1'b0};
			sas_pkg::ST_QM: begin
				m_q <= m_next;
				j_q <= '0;
			end
			sas_pkg::ST_QP: p_q <= sa_rd_q;
			sas_pkg::ST_QC1: begin
				priority if (j_q == plen_q) begin
					found_q <= 1'b1;
				end else if (pos >= QW'(n_q)) begin
					l_q <= signed'(m_plus);
				end
			end
			sas_pkg::ST_QC2: begin
				priority if (key_now == pkey) begin
					j_q <= j_q + PW'(1);
				end else if (key_now < pkey) begin
					l_q <= signed'(m_plus);
				end else begin
					r_q <= signed'(m_minus);
				end
			end
			default: begin
			end
		endcase
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (cmd.op == sas_pkg::ST_BDONE) begin
			kind_q   <= sas_pkg::KIND_BUILD;
			rfound_q <= 1'b0;
			rank_q   <= '0;
			rstat_q  <= ovf_q[0] ? sas_pkg::STAT_TEXT_OVF : sas_pkg::STAT_OK;
		end else if (cmd.op == sas_pkg::ST_QDONE) begin
			kind_q   <= sas_pkg::KIND_QUERY;
			rfound_q <= built_q && found_q;
			rank_q   <= (built_q && found_q) ? rank_ext[RW-1:0] : '0;
			priority if (!built_q) begin
				rstat_q <= sas_pkg::STAT_NO_BUILD;
			end else if (ovf_q[1]) begin
				rstat_q <= sas_pkg::STAT_PAT_OVF;
			end else begin
				rstat_q <= sas_pkg::STAT_OK;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign res_kind   = kind_q;
	assign res_found  = rfound_q;
	assign res_rank   = rank_q;
	assign res_status = rstat_q;

	// Status to the sequencer.
	assign stat.out_busy  = out_valid_q;
	assign stat.built     = built_q;
	assign stat.last_i    = last_i;
	assign stat.last_k    = last_k;
	assign stat.n_gt1     = (n_q > NW'(1));
	assign stat.dbl_lt_n  = ({shift_q, 1'b0} < (NW+1)'(n_q));
	assign stat.r_lt_l    = (r_q < l_q);
	assign stat.j_eq_plen = (j_q == plen_q);
	assign stat.pos_ge_n  = (pos >= QW'(n_q));
	assign stat.cmp_eq    = (key_now == pkey);

endmodule

// ===== hdl/suffix_array_substring_search.sv =====
// A symbol word yields no result. A build sorts the suffixes in single-port walks
// over the sort memories, for n = text length + 1 suffixes. A query probe reads the
// suffix start and then compares the pattern symbol by symbol until a mismatch or its
// end, over at most floor(log2 n)+1 probes, before the result is written. One build
// or query is in flight at a time. Reset clears lengths, flags and the sequencer at
// once; the memories need no clearing pass.
module suffix_array_substring_search #(
	parameter int TEXT_MAX    = sas_pkg::TEXT_MAX_DEF,
	parameter int PATTERN_MAX = sas_pkg::PATTERN_MAX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sas_in_if.sink     in_ch,
	sas_out_if.source  out_ch
);

	sas_pkg::cmd_t  cmd;
	sas_pkg::stat_t stat;

	// Sequencer.
	sas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.action   (in_ch.action),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Memories and arithmetic.
	sas_dp #(
		.TEXT_MAX    (TEXT_MAX),
		.PATTERN_MAX (PATTERN_MAX)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (in_ch.action),
		.symbol     (in_ch.symbol),
		.stat       (stat),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.res_kind   (out_ch.result_kind),
		.res_found  (out_ch.found),
		.res_rank   (out_ch.match_rank),
		.res_status (out_ch.status)
	);

endmodule

// ===== hdl/sas_chk.sv =====
// Port-level checks of the suffix array block, bound to the top level.
// Depends on sas_pkg for the action, kind and status codes.
module sas_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  action,
	input logic        out_valid,
	input logic        out_ready,
	input logic        result_kind,
	input logic        found,
	input logic [10:0] match_rank,
	input logic [1:0]  status
);

	// A waiting result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({result_kind, found, match_rank, status}))
		else $error("result word changed while stalled");

	// A build result carries no match and only a text status.
	a_build_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == sas_pkg::KIND_BUILD |->
		!found && match_rank == '0 &&
		(status == sas_pkg::STAT_OK || status == sas_pkg::STAT_TEXT_OVF))
		else $error("malformed build result");

	// A query without a match reports rank zero and never a text status.
	a_query_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == sas_pkg::KIND_QUERY && !found |->
		match_rank == '0 && status != sas_pkg::STAT_TEXT_OVF)
		else $error("malformed query result");

	// A build or query word occupies the block on the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == sas_pkg::ACT_BUILD || action == sas_pkg::ACT_QUERY)
		|=> !in_ready)
		else $error("input taken while a build or query runs");

endmodule

bind suffix_array_substring_search sas_chk u_sas_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.action      (in_ch.action),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.result_kind (out_ch.result_kind),
	.found       (out_ch.found),
	.match_rank  (out_ch.match_rank),
	.status      (out_ch.status)
);

// ===== test/tb.sv =====
// Testbench of the suffix array substring search block: directed table, then random texts,
// patterns and queries, checked word by word against a behavioral suffix sorter.
// Depends on sas_pkg and the sas_in_if / sas_out_if interfaces.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TMAX = sas_pkg::TEXT_MAX_DEF;
	localparam int PMAX = sas_pkg::PATTERN_MAX_DEF;

	typedef struct packed {
		sas_pkg::kind_t   kind;
		logic             found;
		logic [10:0]      rank;
		sas_pkg::status_t status;
	} answer_t;

	typedef struct {
		sas_pkg::action_t act;
		logic [7:0]       sym;
		bit               typed;
		answer_t          ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	sas_in_if  in_ch ();
	sas_out_if out_ch ();

	suffix_array_substring_search dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model state of the text, pattern and sorted suffixes.
	logic [7:0] text_mem [TMAX];
	int         text_len;
	int         sorted_pos [TMAX + 1];
	logic [7:0] pat_mem [PMAX];
	int         pat_len;
	bit         is_built;
	bit         text_ovf, pat_ovf;

	answer_t answer_q [$];
	int      errors;
	bit      quiet;

	task automatic report(input string what, input answer_t got, input answer_t exp);
		$display("MISMATCH %s: got %p expected %p at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	// Append an expected result word behind the ones already waiting.
	function automatic void queue_answer(input answer_t a);
		answer_q.insert(answer_q.size(), a);
	endfunction

	function automatic int sort_key(input int p);
		return (p < text_len) ? int'(text_mem[p]) + 1 : 0;
	endfunction

	// Prefix doubling sort of all suffixes including the sentinel.
	function automatic void sort_suffixes();
		int n, shift, i, s, t;
		int cls [TMAX + 1], ncls [TMAX + 1], tmp [TMAX + 1], cnt [TMAX + 1];
		int kcnt [sas_pkg::NKEYS];
		n = text_len + 1;
		foreach (kcnt[k]) kcnt[k] = 0;
		for (i = 0; i < n; i++) kcnt[sort_key(i)]++;
		s = 0;
		for (i = 0; i < sas_pkg::NKEYS; i++) begin
			t = kcnt[i]; kcnt[i] = s; s += t;
		end
		for (i = 0; i < n; i++) sorted_pos[kcnt[sort_key(i)]++] = i;
		cls[sorted_pos[0]] = 0;
		for (i = 1; i < n; i++)
			cls[sorted_pos[i]] = cls[sorted_pos[i-1]] +
				((sort_key(sorted_pos[i-1]) == sort_key(sorted_pos[i])) ? 0 : 1);
		for (shift = 1; shift < n; shift <<= 1) begin
			for (i = 0; i < n; i++) sorted_pos[i] = (sorted_pos[i] + n - shift) % n;
			for (i = 0; i < n; i++) cnt[i] = 0;
			for (i = 0; i < n; i++) cnt[cls[i] % n]++;
			s = 0;
			for (i = 0; i < n; i++) begin
				t = cnt[i]; cnt[i] = s; s += t;
			end
			for (i = 0; i < n; i++) begin
				t = cls[sorted_pos[i]] % n;
				tmp[cnt[t] % n] = sorted_pos[i];
				cnt[t]++;
			end
			for (i = 0; i < n; i++) sorted_pos[i] = tmp[i];
			ncls[sorted_pos[0]] = 0;
			for (i = 1; i < n; i++) begin
				int a, b;
				a = sorted_pos[i-1]; b = sorted_pos[i];
				ncls[b] = ncls[a] + ((cls[a] == cls[b] &&
					cls[(a + shift) % n] == cls[(b + shift) % n]) ? 0 : 1);
			end
			for (i = 0; i < n; i++) cls[i] = ncls[i];
		end
	endfunction

	function automatic int compare_suffix(input int p);
		int i, tk, pk;
		for (i = 0; i < pat_len; i++) begin
			if (p + i >= text_len + 1) return -1;
			tk = sort_key(p + i);
			pk = int'(pat_mem[i]) + 1;
			if (tk != pk) return (tk < pk) ? -1 : 1;
		end
		return 0;
	endfunction

	// Advance the model by one word; returns 1 when a result is due.
	function automatic bit predict_word(input sas_pkg::action_t act, input logic [7:0] sym,
			output answer_t ans);
		int l, r, m, c;
		ans = '{sas_pkg::KIND_BUILD, 1'b0, 11'd0, sas_pkg::STAT_OK};
		case (act)
			sas_pkg::ACT_TEXT: begin
				if (is_built) begin
					is_built = 0; text_len = 0; text_ovf = 0;
				end
				if (text_len < TMAX) text_mem[text_len++] = sym;
				else text_ovf = 1;
				return 0;
			end
			sas_pkg::ACT_PAT: begin
				if (pat_len < PMAX) pat_mem[pat_len++] = sym;
				else pat_ovf = 1;
				return 0;
			end
			sas_pkg::ACT_BUILD: begin
				sort_suffixes();
				is_built = 1;
				ans.status = text_ovf ? sas_pkg::STAT_TEXT_OVF : sas_pkg::STAT_OK;
				text_ovf = 0;
				return 1;
			end
			default: begin
				ans.kind = sas_pkg::KIND_QUERY;
				if (!is_built) ans.status = sas_pkg::STAT_NO_BUILD;
				else begin
					l = 0; r = text_len;
					while (r >= l) begin
						m = (l + r) / 2;
						c = compare_suffix(sorted_pos[m]);
						if (c == 0) begin
							ans.found = 1; ans.rank = m[10:0];
							break;
						end
						if (c < 0) l = m + 1; else r = m - 1;
					end
					ans.status = pat_ovf ? sas_pkg::STAT_PAT_OVF : sas_pkg::STAT_OK;
				end
				pat_ovf = 0; pat_len = 0;
				return 1;
			end
		endcase
	endfunction

	// Send one word, idling in bursts before it unless quiet.
	task automatic send_word(input sas_pkg::action_t act, input logic [7:0] sym);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.action <= act;
		in_ch.symbol <= sym;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic apply(input sas_pkg::action_t act, input logic [7:0] sym);
		answer_t a;
		if (predict_word(act, sym, a)) queue_answer(a);
		send_word(act, sym);
	endtask

	// Result side: random stalls, compare against the oldest expectation.
	always @(posedge clk) begin
		answer_t got, exp;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{sas_pkg::kind_t'(out_ch.result_kind), out_ch.found, out_ch.match_rank,
				sas_pkg::status_t'(out_ch.status)};
			if (answer_q.size() == 0) begin
				report("unexpected result", got, got);
			end else begin
				exp = answer_q.pop_front();
				if (got.kind !== exp.kind) report("result_kind", got, exp);
				if (got.found !== exp.found) report("found", got, exp);
				if (got.rank !== exp.rank) report("match_rank", got, exp);
				if (got.status !== exp.status) report("status", got, exp);
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Directed table: typed answers only where obvious.
	row_t table_rows [] = '{
		'{sas_pkg::ACT_QUERY, 8'h00, 1,
			'{sas_pkg::KIND_QUERY, 1'b0, 11'd0, sas_pkg::STAT_NO_BUILD}},
		'{sas_pkg::ACT_BUILD, 8'h00, 1,
			'{sas_pkg::KIND_BUILD, 1'b0, 11'd0, sas_pkg::STAT_OK}},
		'{sas_pkg::ACT_QUERY, 8'hFF, 0, '0},
		'{sas_pkg::ACT_TEXT,  8'h00, 0, '0},
		'{sas_pkg::ACT_TEXT,  8'hFF, 0, '0},
		'{sas_pkg::ACT_TEXT,  8'h00, 0, '0},
		'{sas_pkg::ACT_TEXT,  8'hFF, 0, '0},
		'{sas_pkg::ACT_TEXT,  8'h00, 0, '0},
		'{sas_pkg::ACT_BUILD, 8'hAA, 1,
			'{sas_pkg::KIND_BUILD, 1'b0, 11'd0, sas_pkg::STAT_OK}},
		'{sas_pkg::ACT_PAT,   8'hFF, 0, '0},
		'{sas_pkg::ACT_PAT,   8'h00, 0, '0},
		'{sas_pkg::ACT_QUERY, 8'h55, 0, '0},
		'{sas_pkg::ACT_PAT,   8'h00, 0, '0},
		'{sas_pkg::ACT_QUERY, 8'h00, 0, '0},
		'{sas_pkg::ACT_PAT,   8'h01, 0, '0},
		'{sas_pkg::ACT_QUERY, 8'h00, 0, '0},
		'{sas_pkg::ACT_BUILD, 8'h00, 1,
			'{sas_pkg::KIND_BUILD, 1'b0, 11'd0, sas_pkg::STAT_OK}},
		'{sas_pkg::ACT_PAT,   8'h00, 0, '0},
		'{sas_pkg::ACT_PAT,   8'hFF, 0, '0},
		'{sas_pkg::ACT_PAT,   8'h00, 0, '0},
		'{sas_pkg::ACT_PAT,   8'hFF, 0, '0},
		'{sas_pkg::ACT_QUERY, 8'h00, 0, '0}
	};

	initial begin
		in_ch.valid  <= 1'b0;
		in_ch.action <= sas_pkg::ACT_TEXT;
		in_ch.symbol <= 8'h00;
		text_len = 0; pat_len = 0; is_built = 0; text_ovf = 0; pat_ovf = 0;
		errors = 0; quiet = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows.
		foreach (table_rows[i]) begin
			answer_t a;
			if (predict_word(table_rows[i].act, table_rows[i].sym, a))
				queue_answer(table_rows[i].typed ? table_rows[i].ans : a);
			send_word(table_rows[i].act, table_rows[i].sym);
		end

		// A long text over a small alphabet, then a pattern overflow.
		for (int i = 0; i < 200; i++) apply(sas_pkg::ACT_TEXT, 8'($urandom_range(0, 3)));
		apply(sas_pkg::ACT_BUILD, 8'h00);
		for (int i = 0; i < PMAX + 2; i++) apply(sas_pkg::ACT_PAT, 8'($urandom_range(0, 3)));
		apply(sas_pkg::ACT_QUERY, 8'h00);
		apply(sas_pkg::ACT_PAT, 8'h01);
		apply(sas_pkg::ACT_QUERY, 8'h00);

		// Random sessions: small texts over small or full byte alphabets, patterns mostly cut from the text.
		for (int s = 0; s < 22; s++) begin
			int tl, alpha;
			if (s == 18) quiet = 1;
			tl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
			alpha = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 3);
			for (int i = 0; i < tl; i++)
				apply(sas_pkg::ACT_TEXT, 8'($urandom_range(0, alpha)));
			if ($urandom_range(0, 9) != 0) apply(sas_pkg::ACT_BUILD, 8'($urandom));
			for (int q = 0; q < 3; q++) begin
				int pl, st;
				pl = $urandom_range(0, 5);
				st = (text_len > 0) ? $urandom_range(0, text_len - 1) : 0;
				for (int i = 0; i < pl; i++) begin
					if ($urandom_range(0, 3) != 0 && st + i < text_len)
						apply(sas_pkg::ACT_PAT, text_mem[st + i]);
					else apply(sas_pkg::ACT_PAT, 8'($urandom_range(0, alpha)));
				end
				apply(sas_pkg::ACT_QUERY, 8'($urandom));
			end
		end
		in_ch.valid <= 1'b0;

		fork
			wait (answer_q.size() == 0);
			begin
				repeat (200000) @(posedge clk);
			end
		join_any
		disable fork;
		repeat (200) @(posedge clk);
		if (errors == 0 && answer_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#(20_000_000);
		$display("Some tests failed");
		$finish;
	end
endmodule
